/* hw/rtl/pots_pkg.sv */
`default_nettype none

package pots_pkg;

  localparam int TAG_W       = 32;
  localparam int COUNT_W     = 32;
  localparam int TIME_W      = 32;
  localparam int AGE_TOTAL_W = 48;
  localparam int STAT_W      = 48;
  localparam int NUM_CNT     = 8;

  localparam int OP_W    = 3;
  localparam int KIND_W  = 2;
  localparam int OUTC_W  = 2;
  localparam int SIDX_W  = 4;

  localparam logic [OP_W-1:0] OP_SUBMIT = 3'd0;
  localparam logic [OP_W-1:0] OP_TAKE   = 3'd1;
  localparam logic [OP_W-1:0] OP_REPORT = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  localparam logic [KIND_W-1:0] KIND_LOCAL   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MAINT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSURE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE   = 2'd3;

  localparam int CNT_SUBMITTED = 0;
  localparam int CNT_EXECUTED  = 1;
  localparam int CNT_DROPPED   = 2;
  localparam int CNT_SAMPLES   = 3;
  localparam int CNT_COMMITTED = 4;

  localparam logic [SIDX_W-1:0] STAT_SUBMITTED = 4'd0;
  localparam logic [SIDX_W-1:0] STAT_EXECUTED  = 4'd1;
  localparam logic [SIDX_W-1:0] STAT_DROPPED   = 4'd2;
  localparam logic [SIDX_W-1:0] STAT_PENDING   = 4'd3;
  localparam logic [SIDX_W-1:0] STAT_AGE_MAX   = 4'd4;
  localparam logic [SIDX_W-1:0] STAT_AGE_TOTAL = 4'd5;
  localparam logic [SIDX_W-1:0] STAT_SAMPLES   = 4'd6;
  localparam logic [SIDX_W-1:0] STAT_COMMITTED = 4'd7;
  localparam logic [SIDX_W-1:0] STAT_STALE     = 4'd8;
  localparam logic [SIDX_W-1:0] STAT_INVALID   = 4'd9;
  localparam logic [SIDX_W-1:0] STAT_NOT_FOUND = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/pots_item_if.sv */
`default_nettype none

interface pots_item_if;
  logic                           valid;
  logic                           ready;
  logic [pots_pkg::OP_W-1:0]      operation;
  logic [pots_pkg::KIND_W-1:0]    task_kind;
  logic [pots_pkg::TAG_W-1:0]     task_tag;
  logic [pots_pkg::OUTC_W-1:0]    outcome_code;
  logic [pots_pkg::SIDX_W-1:0]    stat_index;

  modport source (
    output valid, operation, task_kind, task_tag, outcome_code, stat_index,
    input  ready
  );
  modport sink (
    input  valid, operation, task_kind, task_tag, outcome_code, stat_index,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/pots_result_if.sv */
`default_nettype none

interface pots_result_if;
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic                         displaced;
  logic                         task_valid;
  logic [pots_pkg::KIND_W-1:0]  out_kind;
  logic [pots_pkg::TAG_W-1:0]   out_tag;
  logic [pots_pkg::TIME_W-1:0]  wait_age;
  logic                         pending;
  logic [pots_pkg::STAT_W-1:0]  stat_value;

  modport source (
    output valid, accepted, displaced, task_valid, out_kind, out_tag, wait_age,
           pending, stat_value,
    input  ready
  );
  modport sink (
    input  valid, accepted, displaced, task_valid, out_kind, out_tag, wait_age,
           pending, stat_value,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/pots_ctrl.sv */
`default_nettype none

module pots_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output pots_pkg::dp_cmd_t      cmd
);

  pots_pkg::state_t state;
  pots_pkg::state_t state_next;

  // Take a beat only when the result register is free or draining this cycle.
  assign item_ready  = (state == pots_pkg::ST_IDLE) && (!result_valid || result_ready);
  assign cmd.capture = item_valid && item_ready;
  assign cmd.execute = (state == pots_pkg::ST_EXEC);

  always_comb begin
    case (state)
      pots_pkg::ST_IDLE: state_next = cmd.capture ? pots_pkg::ST_EXEC : pots_pkg::ST_IDLE;
      pots_pkg::ST_EXEC: state_next = pots_pkg::ST_IDLE;
      default:           state_next = pots_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pots_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.execute) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_capture_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.execute)
    else $error("captured beat not executed next cycle");

  a_exec_sets_result: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> result_valid)
    else $error("execute did not load the result register");

  a_exec_result_free: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |-> !result_valid)
    else $error("execute would overwrite a waiting result");

endmodule

`default_nettype wire

/* hw/rtl/pots_dpath.sv */
`default_nettype none

module pots_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pots_pkg::dp_cmd_t             cmd,
  input  wire logic [pots_pkg::OP_W-1:0]     operation,
  input  wire logic [pots_pkg::KIND_W-1:0]   task_kind,
  input  wire logic [pots_pkg::TAG_W-1:0]    task_tag,
  input  wire logic [pots_pkg::OUTC_W-1:0]   outcome_code,
  input  wire logic [pots_pkg::SIDX_W-1:0]   stat_index,
  output logic                               accepted,
  output logic                               displaced,
  output logic                               task_valid,
  output logic [pots_pkg::KIND_W-1:0]        out_kind,
  output logic [pots_pkg::TAG_W-1:0]         out_tag,
  output logic [pots_pkg::TIME_W-1:0]        wait_age,
  output logic                               pending,
  output logic [pots_pkg::STAT_W-1:0]        stat_value
);

  // captured beat
  logic [pots_pkg::OP_W-1:0]   cap_op;
  logic [pots_pkg::KIND_W-1:0] cap_kind;
  logic [pots_pkg::TAG_W-1:0]  cap_tag;
  logic [pots_pkg::OUTC_W-1:0] cap_outc;
  logic [pots_pkg::SIDX_W-1:0] cap_sidx;

  // block state
  logic                            slot_full;
  logic [pots_pkg::KIND_W-1:0]     slot_kind;
  logic [pots_pkg::TAG_W-1:0]      slot_tag;
  logic [pots_pkg::TIME_W-1:0]     slot_enqueue_time;
  logic [pots_pkg::TIME_W-1:0]     now_ticks;
  logic [pots_pkg::COUNT_W-1:0]    event_counters [pots_pkg::NUM_CNT];
  logic [pots_pkg::TIME_W-1:0]     age_maximum;
  logic [pots_pkg::AGE_TOTAL_W-1:0] age_total;

  logic [pots_pkg::KIND_W-1:0]     kind_norm;
  logic                            is_submit;
  logic                            is_take;
  logic                            take_slot;
  logic [pots_pkg::TIME_W-1:0]     age;
  logic                            slot_full_next;
  logic [pots_pkg::NUM_CNT-1:0]    bump;
  logic [pots_pkg::STAT_W-1:0]     sval;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_op   <= operation;
      cap_kind <= task_kind;
      cap_tag  <= task_tag;
      cap_outc <= outcome_code;
      cap_sidx <= stat_index;
    end
  end

  // The spare kind code is stored as a local adjustment.
  assign kind_norm = (cap_kind == pots_pkg::KIND_SPARE) ? pots_pkg::KIND_LOCAL : cap_kind;
  assign is_submit = (cap_op == pots_pkg::OP_SUBMIT);
  assign is_take   = (cap_op == pots_pkg::OP_TAKE) && slot_full;
  assign take_slot = (kind_norm == pots_pkg::KIND_CLOSURE) || !slot_full ||
                     (slot_kind == pots_pkg::KIND_LOCAL);
  assign age       = now_ticks - slot_enqueue_time;

  always_comb begin
    slot_full_next = slot_full;
    if (is_submit && take_slot) begin
      slot_full_next = 1'b1;
    end else if (is_take) begin
      slot_full_next = 1'b0;
    end
  end

  always_comb begin
    bump = '0;
    bump[pots_pkg::CNT_SUBMITTED] = is_submit;
    bump[pots_pkg::CNT_DROPPED]   = is_submit && (!take_slot || slot_full);
    bump[pots_pkg::CNT_EXECUTED]  = is_take;
    bump[pots_pkg::CNT_SAMPLES]   = is_take;
    for (int i = 0; i < pots_pkg::NUM_CNT - pots_pkg::CNT_COMMITTED; i++) begin
      bump[pots_pkg::CNT_COMMITTED + i] = (cap_op == pots_pkg::OP_REPORT) &&
                                          (cap_outc == pots_pkg::OUTC_W'(i));
    end
  end

  always_comb begin
    case (cap_sidx)
      pots_pkg::STAT_SUBMITTED:
        sval = pots_pkg::STAT_W'(event_counters[pots_pkg::CNT_SUBMITTED]);
      pots_pkg::STAT_EXECUTED:
        sval = pots_pkg::STAT_W'(event_counters[pots_pkg::CNT_EXECUTED]);
      pots_pkg::STAT_DROPPED:
        sval = pots_pkg::STAT_W'(event_counters[pots_pkg::CNT_DROPPED]);
      pots_pkg::STAT_PENDING:
        sval = pots_pkg::STAT_W'(slot_full);
      pots_pkg::STAT_AGE_MAX:
        sval = pots_pkg::STAT_W'(age_maximum);
      pots_pkg::STAT_AGE_TOTAL:
        sval = pots_pkg::STAT_W'(age_total);
      pots_pkg::STAT_SAMPLES:
        sval = pots_pkg::STAT_W'(event_counters[pots_pkg::CNT_SAMPLES]);
      pots_pkg::STAT_COMMITTED:
        sval = pots_pkg::STAT_W'(event_counters[pots_pkg::CNT_COMMITTED]);
      pots_pkg::STAT_STALE:
        sval = pots_pkg::STAT_W'(event_counters[pots_pkg::CNT_COMMITTED + 1]);
      pots_pkg::STAT_INVALID:
        sval = pots_pkg::STAT_W'(event_counters[pots_pkg::CNT_COMMITTED + 2]);
      pots_pkg::STAT_NOT_FOUND:
        sval = pots_pkg::STAT_W'(event_counters[pots_pkg::CNT_COMMITTED + 3]);
      default:
        sval = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_full         <= 1'b0;
      slot_kind         <= pots_pkg::KIND_LOCAL;
      slot_tag          <= '0;
      slot_enqueue_time <= '0;
      now_ticks         <= '0;
      age_maximum       <= '0;
      age_total         <= '0;
      for (int i = 0; i < pots_pkg::NUM_CNT; i++) begin
        event_counters[i] <= '0;
      end
    end else if (cmd.execute) begin
      slot_full <= slot_full_next;
      if (is_submit && take_slot) begin
        slot_kind         <= kind_norm;
        slot_tag          <= cap_tag;
        slot_enqueue_time <= now_ticks;
      end
      if (is_take) begin
        if (age > age_maximum) begin
          age_maximum <= age;
        end
        age_total <= age_total + pots_pkg::AGE_TOTAL_W'(age);
      end
      if (cap_op == pots_pkg::OP_TICK) begin
        now_ticks <= now_ticks + 1'b1;
      end
      for (int i = 0; i < pots_pkg::NUM_CNT; i++) begin
        if (bump[i]) begin
          event_counters[i] <= event_counters[i] + 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      accepted   <= is_submit && take_slot;
      displaced  <= is_submit && take_slot && slot_full;
      task_valid <= is_take;
      out_kind   <= is_take ? slot_kind : pots_pkg::KIND_LOCAL;
      out_tag    <= is_take ? slot_tag : '0;
      wait_age   <= is_take ? age : '0;
      pending    <= slot_full_next;
      stat_value <= (cap_op == pots_pkg::OP_READ) ? sval : '0;
    end
  end

  a_pending_tracks_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> (pending == slot_full))
    else $error("pending flag disagrees with slot state");

  a_take_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.execute && is_take) |=> !slot_full)
    else $error("take left the slot full");

  a_closure_taken: assert property (@(posedge clk) disable iff (rst)
    (cmd.execute && is_submit && (kind_norm == pots_pkg::KIND_CLOSURE)) |=> (accepted && slot_full))
    else $error("loop-closure task was rejected");

endmodule

`default_nettype wire

/* hw/rtl/priority_overwrite_task_slot.sv */
// Priority overwrite task slot: one-entry task mailbox with statistics.
// Channel item (sink): one beat per operation - submit, take, report outcome,
// time tick or read statistic - carrying operation, task_kind, task_tag,
// outcome_code and stat_index.
// Channel result (source): exactly one beat for every item beat, in order,
// carrying accepted, displaced, task_valid, out_kind, out_tag, wait_age,
// pending and stat_value; fields that do not apply to the operation are zero.
// Result path: the item beat is taken into the capture register, the captured
// beat executes in the EXEC state and loads the result register at its end.
// Flow: no new item is taken while the captured one executes, as set by the
// capture/execute sequence of the controller; the next item is taken at the
// earliest in the cycle in which the previous result drains.
// Reset (rst, synchronous): slot empty, tick counter, ages and all event
// counters cleared, no result pending.
// Receiver stall: the result register holds its beat until result.ready, and
// item.ready stays low until the waiting beat drains.
`default_nettype none

module priority_overwrite_task_slot (
  input  wire logic    clk,
  input  wire logic    rst,
  pots_item_if.sink    item,
  pots_result_if.source result
);

  pots_pkg::dp_cmd_t cmd;

  pots_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd)
  );

  pots_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .operation    (item.operation),
    .task_kind    (item.task_kind),
    .task_tag     (item.task_tag),
    .outcome_code (item.outcome_code),
    .stat_index   (item.stat_index),
    .accepted     (result.accepted),
    .displaced    (result.displaced),
    .task_valid   (result.task_valid),
    .out_kind     (result.out_kind),
    .out_tag      (result.out_tag),
    .wait_age     (result.wait_age),
    .pending      (result.pending),
    .stat_value   (result.stat_value)
  );

endmodule

`default_nettype wire
